// ===== rtl/lst_pkg.sv =====
// Shared types, constants and the arctangent table for the laser scan to point cloud block.
// Used by lst_cordic and laser_scan_to_point_cloud; depends on nothing else.
package lst_pkg;

  // Default parameter values
  localparam int MAX_BEAMS_DEF    = 4096;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // Field and register widths
  localparam int RANGE_W    = 24;
  localparam int ANGLE_W    = 16;
  localparam int STEP_W     = 15;
  localparam int BPS_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PX_W       = 20;
  localparam int PY_W       = 19;
  localparam int BEAM_NUM_W = 12;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BEAMS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH       = 3'd6;

  // Register reset values
  localparam logic [RANGE_W-1:0] RANGE_LOW_RST   = 24'd0;
  localparam logic [RANGE_W-1:0] RANGE_HIGH_RST  = 24'd1966080;
  localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'hA000;
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 15'd64;
  localparam logic [BPS_W-1:0]   BEAMS_RST       = 13'd1024;

  // CORDIC datapath: Q2.30 values with headroom, 32 bit phase
  localparam int TRIG_W     = 34;
  localparam int ATAN_IDX_W = 5;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [TRIG_W-1:0] HALF_PI     = 34'sh040000000;
  localparam logic signed [TRIG_W-1:0] PI_PHASE    = 34'sh080000000;

  // Result of one CORDIC run
  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } trig_t;

  // Arctangent of 2^-idx as a 32 bit phase
  function automatic logic signed [TRIG_W-1:0] atan_phase(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [TRIG_W-1:0] ph;
    unique case (idx)
      5'd0:    ph = 34'sh020000000;
      5'd1:    ph = 34'sh012E4051E;
      5'd2:    ph = 34'sh009FB385B;
      5'd3:    ph = 34'sh0051111D4;
      5'd4:    ph = 34'sh0028B0D43;
      5'd5:    ph = 34'sh00145D7E1;
      5'd6:    ph = 34'sh000A2F61E;
      5'd7:    ph = 34'sh000517C55;
      5'd8:    ph = 34'sh00028BE53;
      5'd9:    ph = 34'sh000145F2F;
      5'd10:   ph = 34'sh0000A2F98;
      5'd11:   ph = 34'sh0000517CC;
      5'd12:   ph = 34'sh000028BE6;
      5'd13:   ph = 34'sh0000145F3;
      5'd14:   ph = 34'sh00000A2FA;
      5'd15:   ph = 34'sh00000517D;
      5'd16:   ph = 34'sh0000028BE;
      5'd17:   ph = 34'sh00000145F;
      5'd18:   ph = 34'sh000000A30;
      5'd19:   ph = 34'sh000000518;
      5'd20:   ph = 34'sh00000028C;
      5'd21:   ph = 34'sh000000146;
      5'd22:   ph = 34'sh0000000A3;
      5'd23:   ph = 34'sh000000051;
      default: ph = '0;
    endcase
    return ph;
  endfunction

endpackage

// ===== rtl/lst_cordic.sv =====
// Iterative CORDIC in rotation mode: cosine and sine of a 16 bit angle, one step per cycle.
// Depends on lst_pkg for widths, gain, arctangent table and the trig_t result type.
module lst_cordic #(
  parameter int STEPS = lst_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lst_pkg::ANGLE_W-1:0]  angle,
  output lst_pkg::trig_t               res
);

  localparam int TW  = lst_pkg::TRIG_W;
  localparam int AW  = lst_pkg::ATAN_IDX_W;
  localparam int CW  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic                 busy;
  logic                 done;
  logic                 flip;
  logic [CW-1:0]        step;
  logic signed [TW-1:0] x, y, z;
  logic signed [TW-1:0] x_next, y_next, z_next;
  logic signed [TW-1:0] x_sh, y_sh, ang;
  logic signed [TW-1:0] z_init;

  // Scale the start angle to a signed 32 bit phase; it is folded into the right half plane on load
  assign z_init = TW'($signed({angle, 16'h0000}));

  // One rotation step
  always_comb begin
    x_sh = x >>> step;
    y_sh = y >>> step;
    ang  = lst_pkg::atan_phase(AW'(step));
    if (z >= 0) begin
      x_next = x - y_sh;
      y_next = y + x_sh;
      z_next = z - ang;
    end else begin
      x_next = x + y_sh;
      y_next = y - x_sh;
      z_next = z + ang;
    end
  end

  // Control: start, count steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, rotate while busy
  always_ff @(posedge clk) begin
    if (start) begin
      x <= lst_pkg::CORDIC_GAIN;
      y <= '0;
      if (z_init > lst_pkg::HALF_PI) begin
        z    <= z_init - lst_pkg::PI_PHASE;
        flip <= 1'b1;
      end else if (z_init < -lst_pkg::HALF_PI) begin
        z    <= z_init + lst_pkg::PI_PHASE;
        flip <= 1'b1;
      end else begin
        z    <= z_init;
        flip <= 1'b0;
      end
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  assign res.done    = done;
  assign res.cos_val = flip ? -x : x;
  assign res.sin_val = flip ? -y : y;

endmodule

// ===== rtl/laser_scan_to_point_cloud.sv =====
// Laser scan to point cloud: per beam range sample to a rotated, offset, clipped x/y point.
// Uses lst_pkg and one lst_cordic instance shared by the beam, pitch and roll angles.
// In the range window: three CORDIC runs (beam, pitch, roll), six products on one 34x34
// multiplier, each registered then rounded and written back, sum, load. Outside the window or
// past the beam count: load only. A new request is taken only when idle, after the last is loaded;
// output stalls hold it. Synchronous reset loads register defaults, index 0, start angle.
module laser_scan_to_point_cloud #(
  parameter int MAX_BEAMS    = lst_pkg::MAX_BEAMS_DEF,
  parameter int CORDIC_STEPS = lst_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = lst_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lst_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lst_pkg::RANGE_W-1:0]         range_sample,
  input  logic                                scan_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                point_valid,
  output logic signed [lst_pkg::PX_W-1:0]     point_x,
  output logic signed [lst_pkg::PY_W-1:0]     point_y,
  output logic [lst_pkg::BEAM_NUM_W-1:0]      beam_number,
  output logic                                scan_end
);

  localparam int TW    = lst_pkg::TRIG_W;
  localparam int PW    = 2 * TW;
  localparam int SW    = TW + 1;
  localparam int IDX_W = $clog2(MAX_BEAMS + 1);
  localparam int CNT_W = (IDX_W > lst_pkg::BPS_W) ? IDX_W : lst_pkg::BPS_W;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BEAMS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BEAMS);
  localparam logic signed [SW-1:0] OFF_X =
    SW'(((64'd305 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic signed [SW-1:0] LIM_X = SW'(64'd4 << FRAC_BITS);
  localparam logic signed [SW-1:0] LIM_Y = SW'(64'd3 << FRAC_BITS);
  localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << 29);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TBEAM  = 3'd1;
  localparam logic [2:0] S_TPITCH = 3'd2;
  localparam logic [2:0] S_TROLL  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_WB     = 3'd5;
  localparam logic [2:0] S_SUM    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // Multiplier operations
  localparam logic [2:0] OP_PX  = 3'd0;
  localparam logic [2:0] OP_PY  = 3'd1;
  localparam logic [2:0] OP_XS  = 3'd2;
  localparam logic [2:0] OP_YA  = 3'd3;
  localparam logic [2:0] OP_SRP = 3'd4;
  localparam logic [2:0] OP_YB  = 3'd5;

  // Configuration registers
  logic [lst_pkg::RANGE_W-1:0] range_low, range_high;
  logic [lst_pkg::ANGLE_W-1:0] start_angle, roll_angle, pitch_angle;
  logic [lst_pkg::STEP_W-1:0]  angle_step;
  logic [lst_pkg::BPS_W-1:0]   beams_per_scan;

  // Scan state
  logic [IDX_W-1:0]            beam_index;
  logic [lst_pkg::ANGLE_W-1:0] beam_angle;

  // Sequencer and datapath
  logic [2:0]                  state;
  logic [2:0]                  op;
  logic [lst_pkg::RANGE_W-1:0] r_hold;
  logic signed [TW-1:0]        ca, sa, cp, sp, cr, sr;
  logic signed [TW-1:0]        px, py, xs, ya, srp, yb;
  logic signed [TW-1:0]        mul_a, mul_b;
  logic signed [PW-1:0]        prod, prod_rnd;
  logic signed [TW-1:0]        rnd;
  logic signed [SW-1:0]        sum_x, sum_y;
  logic                        keep;

  // Pending result
  logic                          pend_valid, pend_end;
  logic signed [lst_pkg::PX_W-1:0] pend_x;
  logic signed [lst_pkg::PY_W-1:0] pend_y;
  logic [lst_pkg::BEAM_NUM_W-1:0]  pend_num;

  // Request decode
  logic                        accept;
  logic [IDX_W-1:0]            idx_cur;
  logic [lst_pkg::ANGLE_W-1:0] angle_cur;
  logic [CNT_W-1:0]            idx_ext, bps_ext, count;
  logic                        in_scan, in_window, last_beam;

  // CORDIC request
  logic                        trig_start;
  logic [lst_pkg::ANGLE_W-1:0] trig_angle;
  lst_pkg::trig_t              trig;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Resolve beam index and angle for this request
  always_comb begin
    idx_cur   = scan_start ? '0 : beam_index;
    angle_cur = scan_start ? start_angle : beam_angle;
    idx_ext   = CNT_W'(idx_cur);
    bps_ext   = CNT_W'(beams_per_scan);
    count     = (bps_ext > MAX_CNT) ? MAX_CNT : bps_ext;
    in_scan   = idx_ext < count;
    last_beam = in_scan && (CNT_W'(idx_ext + 1'b1) == count);
    in_window = (range_sample >= range_low) && (range_sample <= range_high);
  end

  // Pick the CORDIC angle for each run
  always_comb begin
    trig_start = 1'b0;
    trig_angle = angle_cur;
    unique case (state)
      S_IDLE: begin
        trig_start = accept && in_scan && in_window;
      end
      S_TBEAM: begin
        trig_start = trig.done;
        trig_angle = pitch_angle;
      end
      S_TPITCH: begin
        trig_start = trig.done;
        trig_angle = roll_angle;
      end
      default: begin
      end
    endcase
  end

  lst_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (trig_angle),
    .res   (trig)
  );

  // Select multiplier operands
  always_comb begin
    unique case (op)
      OP_PX:   begin mul_a = TW'($signed({1'b0, r_hold})); mul_b = ca;  end
      OP_PY:   begin mul_a = TW'($signed({1'b0, r_hold})); mul_b = sa;  end
      OP_XS:   begin mul_a = cp;  mul_b = px;  end
      OP_YA:   begin mul_a = cr;  mul_b = py;  end
      OP_SRP:  begin mul_a = sr;  mul_b = sp;  end
      OP_YB:   begin mul_a = srp; mul_b = px;  end
      default: begin mul_a = '0;  mul_b = '0;  end
    endcase
  end

  // Round half up and drop 30 fraction bits
  assign prod_rnd = (prod + RND_HALF) >>> 30;
  assign rnd      = prod_rnd[TW-1:0];

  // Final sums and clipping window
  always_comb begin
    sum_x = SW'(xs) + OFF_X;
    sum_y = SW'(ya) + SW'(yb);
    keep  = (sum_x > -LIM_X) && (sum_x < LIM_X) && (sum_y > -LIM_Y) && (sum_y < LIM_Y);
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low      <= lst_pkg::RANGE_LOW_RST;
      range_high     <= lst_pkg::RANGE_HIGH_RST;
      start_angle    <= lst_pkg::START_ANGLE_RST;
      angle_step     <= lst_pkg::ANGLE_STEP_RST;
      beams_per_scan <= lst_pkg::BEAMS_RST;
      roll_angle     <= '0;
      pitch_angle    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lst_pkg::REG_RANGE_LOW:   range_low      <= cfg_data;
        lst_pkg::REG_RANGE_HIGH:  range_high     <= cfg_data;
        lst_pkg::REG_START_ANGLE: start_angle    <= cfg_data[lst_pkg::ANGLE_W-1:0];
        lst_pkg::REG_ANGLE_STEP:  angle_step     <= cfg_data[lst_pkg::STEP_W-1:0];
        lst_pkg::REG_BEAMS:       beams_per_scan <= cfg_data[lst_pkg::BPS_W-1:0];
        lst_pkg::REG_ROLL:        roll_angle     <= cfg_data[lst_pkg::ANGLE_W-1:0];
        lst_pkg::REG_PITCH:       pitch_angle    <= cfg_data[lst_pkg::ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance beam index (saturating) and beam angle on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index <= '0;
      beam_angle <= lst_pkg::START_ANGLE_RST;
    end else if (accept) begin
      beam_index <= (idx_cur < MAX_IDX) ? idx_cur + 1'b1 : idx_cur;
      beam_angle <= angle_cur + lst_pkg::ANGLE_W'(angle_step);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_PX;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (in_scan && in_window) ? S_TBEAM : S_OUT;
          end
        end
        S_TBEAM:  if (trig.done) state <= S_TPITCH;
        S_TPITCH: if (trig.done) state <= S_TROLL;
        S_TROLL: begin
          if (trig.done) begin
            state <= S_MUL;
            op    <= OP_PX;
          end
        end
        S_MUL: state <= S_WB;
        S_WB: begin
          op    <= op + 1'b1;
          state <= (op == OP_YB) ? S_SUM : S_MUL;
        end
        S_SUM: state <= S_OUT;
        S_OUT: if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold request fields, trig results, products and the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      r_hold     <= range_sample;
      pend_num   <= lst_pkg::BEAM_NUM_W'(idx_cur);
      pend_end   <= last_beam;
      pend_valid <= 1'b0;
      pend_x     <= '0;
      pend_y     <= '0;
    end
    if (state == S_TBEAM && trig.done) begin
      ca <= trig.cos_val;
      sa <= trig.sin_val;
    end
    if (state == S_TPITCH && trig.done) begin
      cp <= trig.cos_val;
      sp <= trig.sin_val;
    end
    if (state == S_TROLL && trig.done) begin
      cr <= trig.cos_val;
      sr <= trig.sin_val;
    end
    if (state == S_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_WB) begin
      unique case (op)
        OP_PX:   px  <= rnd;
        OP_PY:   py  <= rnd;
        OP_XS:   xs  <= rnd;
        OP_YA:   ya  <= rnd;
        OP_SRP:  srp <= rnd;
        OP_YB:   yb  <= rnd;
        default: begin
        end
      endcase
    end
    if (state == S_SUM) begin
      pend_valid <= keep;
      pend_x     <= keep ? sum_x[lst_pkg::PX_W-1:0] : '0;
      pend_y     <= keep ? sum_y[lst_pkg::PY_W-1:0] : '0;
    end
  end

  // Output register: load when free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      point_valid <= pend_valid;
      point_x     <= pend_x;
      point_y     <= pend_y;
      beam_number <= pend_num;
      scan_end    <= pend_end;
    end
  end

endmodule
